// ===== hdl/pcbs_pkg.sv =====
// shared types, constants and register indexes of the passive cell balance selector
`timescale 1ns / 1ps

package pcbs_pkg;

    // cell slots carried by every transfer and cells that take part
    localparam int CELL_SLOTS = 5;
    localparam int NUM_CELLS  = 5;

    // field widths
    localparam int MV_W      = 13;
    localparam int TEMP_W    = 8;
    localparam int LOW_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // packed stream widths, rounded up to whole bytes
    localparam int S_FIELDS_W = CELL_SLOTS * MV_W + TEMP_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CELL_SLOTS + LOW_W + STATUS_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic        [MV_W-1:0]       mv_t;
    typedef logic signed [TEMP_W-1:0]     temp_t;
    typedef logic        [LOW_W-1:0]      low_idx_t;
    typedef logic        [CELL_SLOTS-1:0] cell_mask_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MV    = 2'd2;

    // register reset values
    localparam temp_t RST_TEMP_LOW  = 8'sd0;
    localparam temp_t RST_TEMP_HIGH = 8'sd40;
    localparam mv_t   RST_MIN_MV    = 13'd3700;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_TEMP = 2'd1,
        STATUS_LOW  = 2'd2
    } status_t;

    // live configuration handed to the datapath
    typedef struct packed {
        temp_t temp_low;
        temp_t temp_high;
        mv_t   min_mv;
    } cfg_t;

endpackage

// ===== hdl/pcbs_cfg_regs.sv =====
// configuration registers of the passive cell balance selector
`timescale 1ns / 1ps

module pcbs_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pcbs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [pcbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pcbs_pkg::cfg_t                   cfg
);
    import pcbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode a write; indexes past the list leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_TEMP_LOW:  cfg_next.temp_low  = temp_t'(cfg_wdata[TEMP_W-1:0]);
                REG_TEMP_HIGH: cfg_next.temp_high = temp_t'(cfg_wdata[TEMP_W-1:0]);
                REG_MIN_MV:    cfg_next.min_mv    = cfg_wdata[MV_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_low  <= RST_TEMP_LOW;
            cfg_reg.temp_high <= RST_TEMP_HIGH;
            cfg_reg.min_mv    <= RST_MIN_MV;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/pcbs_pair_resolve.sv =====
// builds the bleed marks and resolves adjacent pairs from the lowest index upward
`timescale 1ns / 1ps

module pcbs_pair_resolve (
    input  logic [pcbs_pkg::CELL_SLOTS-2:0] pair_gt,   // bit i: cell i above cell i+1
    input  pcbs_pkg::low_idx_t              lowest,
    output pcbs_pkg::cell_mask_t            mask
);
    import pcbs_pkg::*;

    cell_mask_t mark;

    always_comb begin
        // every taking-part cell but the lowest starts marked
        for (int i = 0; i < CELL_SLOTS; i++) begin
            mark[i] = (i < NUM_CELLS) && (low_idx_t'(i) != lowest);
        end
        // a marked pair keeps the higher cell, the upper one on a tie
        for (int i = 0; i < CELL_SLOTS - 1; i++) begin
            if ((i + 1 < NUM_CELLS) && mark[i] && mark[i+1]) begin
                if (pair_gt[i]) begin
                    mark[i+1] = 1'b0;
                end else begin
                    mark[i] = 1'b0;
                end
            end
        end
        mask = mark;
    end

endmodule

// ===== hdl/passive_cell_balance_select.sv =====
// top level of the passive cell balance selector: three-stage datapath and stream ports
//
// Each input transfer carries five 13-bit cell voltages in mV and a signed 8-bit
// pack temperature; each yields exactly one result with a bleed mask, the index of the
// first lowest cell (zero on a temperature block) and a status code (evaluated,
// temperature outside the window, lowest cell below the minimum voltage).
// The user must write configuration on the plain write port (cfg_we, cfg_addr,
// cfg_wdata) only while no transfer is in flight; the block does not enforce it.
// Indexes past 2 are ignored. An input transfer passes three registered stages to
// m_tvalid: stage one checks the temperature window and compares neighboring cells,
// stage two finds the lowest cell, stage three applies the minimum voltage and
// resolves the pairs into the mask, which sits in the output register.
// Throughput is one transfer per cycle unless the receiver stalls. Each stage has
// its own valid bit and advances when the stage after it is empty or moving, so a
// stalled receiver holds the result in place while bubbles further up still fill;
// nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and restores the register
// defaults (window 0 to 40 C, minimum 3700 mV).
`timescale 1ns / 1ps

module passive_cell_balance_select (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: cell_one_mv, cell_two_mv, cell_three_mv, cell_four_mv,
    // cell_five_mv, temperature_c, zero pad
    input  logic [pcbs_pkg::S_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fields from bit 0: balance_mask, lowest_cell, balance_status, zero pad
    output logic [pcbs_pkg::M_DATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [pcbs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [pcbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pcbs_pkg::*;

    cfg_t cfg;

    pcbs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // stage registers
    logic                  v1_reg, v2_reg, v3_reg;
    mv_t                   mv1_reg [CELL_SLOTS];
    logic                  tblk1_reg;
    logic [CELL_SLOTS-2:0] gt1_reg;
    logic                  tblk2_reg;
    logic [CELL_SLOTS-2:0] gt2_reg;
    low_idx_t              low2_reg;
    mv_t                   lowmv2_reg;
    cell_mask_t            mask3_reg;
    low_idx_t              low3_reg;
    status_t               stat3_reg;

    // next values
    mv_t                   mv1_next [CELL_SLOTS];
    logic                  tblk1_next;
    logic [CELL_SLOTS-2:0] gt1_next;
    low_idx_t              low2_next;
    mv_t                   lowmv2_next;
    cell_mask_t            mask3_next;
    low_idx_t              low3_next;
    status_t               stat3_next;
    temp_t                 temp_in;
    cell_mask_t            resolved_mask;

    // stage advance chain
    logic adv1, adv2, adv3;
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // stage one: unpack, temperature window, neighbor compares
    always_comb begin
        for (int i = 0; i < CELL_SLOTS; i++) begin
            mv1_next[i] = s_tdata[i*MV_W +: MV_W];
        end
        temp_in    = temp_t'(s_tdata[CELL_SLOTS*MV_W +: TEMP_W]);
        tblk1_next = (temp_in < cfg.temp_low) || (temp_in > cfg.temp_high);
        for (int i = 0; i < CELL_SLOTS - 1; i++) begin
            gt1_next[i] = mv1_next[i] > mv1_next[i+1];
        end
    end

    // stage two: first lowest cell by running minimum
    always_comb begin
        low2_next   = '0;
        lowmv2_next = mv1_reg[0];
        for (int i = 1; i < NUM_CELLS; i++) begin
            if (mv1_reg[i] < lowmv2_next) begin
                low2_next   = low_idx_t'(i);
                lowmv2_next = mv1_reg[i];
            end
        end
    end

    pcbs_pair_resolve u_pair (
        .pair_gt (gt2_reg),
        .lowest  (low2_reg),
        .mask    (resolved_mask)
    );

    // stage three: block checks and final mask
    always_comb begin
        if (tblk2_reg) begin
            mask3_next = '0;
            low3_next  = '0;
            stat3_next = STATUS_TEMP;
        end else if (lowmv2_reg < cfg.min_mv) begin
            mask3_next = '0;
            low3_next  = low2_reg;
            stat3_next = STATUS_LOW;
        end else begin
            mask3_next = resolved_mask;
            low3_next  = low2_reg;
            stat3_next = STATUS_OK;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv1) begin
            mv1_reg   <= mv1_next;
            tblk1_reg <= tblk1_next;
            gt1_reg   <= gt1_next;
        end
        if (adv2) begin
            tblk2_reg  <= tblk1_reg;
            gt2_reg    <= gt1_reg;
            low2_reg   <= low2_next;
            lowmv2_reg <= lowmv2_next;
        end
        if (adv3) begin
            mask3_reg <= mask3_next;
            low3_reg  <= low3_next;
            stat3_reg <= stat3_next;
        end
    end

    // result stream
    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}}, stat3_reg, low3_reg, mask3_reg};

endmodule
